// ===== rtl/core/bfi_pkg.sv =====
// ----------------------------------------------------------------------------
// bfi_pkg: shared types and constants of the bit cell to flux interval unit
// Field widths, register indexes and reset values, divider request and
// response records and the configuration record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfi_pkg;

  localparam int POS_BITS      = 24;
  localparam int TIME_BITS     = 40;
  localparam int REV_BITS      = 16;
  localparam int PERIOD_BITS   = 32;
  localparam int INTERVAL_BITS = 32;
  localparam int DIVIDEND_BITS = 64;
  localparam int CODE_BITS     = 2;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = TIME_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_LEN     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_TIME    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_REV       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_POS       = 3'd4;

  localparam logic [PERIOD_BITS-1:0] RST_SAMPLE_PERIOD = 32'd41667;
  localparam logic [POS_BITS-1:0]    RST_TRACK_LEN     = 24'd100000;
  localparam logic [TIME_BITS-1:0]   RST_TRACK_TIME    = 40'd200000000000;
  localparam logic [REV_BITS-1:0]    RST_END_REV       = 16'd1;
  localparam logic [POS_BITS-1:0]    RST_END_POS       = 24'd99999;

  // Rollover codes of a result.
  localparam logic [CODE_BITS-1:0] CODE_NONE     = 2'd0;
  localparam logic [CODE_BITS-1:0] CODE_WRAPPED  = 2'd1;
  localparam logic [CODE_BITS-1:0] CODE_NO_PULSE = 2'd2;

  localparam logic [INTERVAL_BITS-1:0] INTERVAL_SATURATED = '1;

  // Dividend length selects of the serial divider.
  localparam logic [1:0] DIV_LEN_POS  = 2'd0;
  localparam logic [1:0] DIV_LEN_TIME = 2'd1;
  localparam logic [1:0] DIV_LEN_FULL = 2'd2;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] sample_period_ps;
    logic [POS_BITS-1:0]    track_len_cells;
    logic [TIME_BITS-1:0]   track_time_ps;
    logic [REV_BITS-1:0]    stop_revolution;
    logic [POS_BITS-1:0]    end_position;
  } cfg_t;

  typedef struct packed {
    logic                     start;
    logic [1:0]               len_sel;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [PERIOD_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [INTERVAL_BITS-1:0] quotient;
    logic [PERIOD_BITS-1:0]   remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfi_in_if.sv =====
// ----------------------------------------------------------------------------
// bfi_in_if: bit cell input channel
// Carries one bit cell item per handshake: cell duration, data and index bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfi_in_if import bfi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PERIOD_BITS-1:0] left_cell_ps;
  logic                   data_bit;
  logic                   index_bit;

  modport source (output valid, output left_cell_ps, output data_bit, output index_bit,
                  input ready);
  modport sink (input valid, input left_cell_ps, input data_bit, input index_bit,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfi_out_if.sv =====
// ----------------------------------------------------------------------------
// bfi_out_if: flux interval result channel
// Carries one result item per handshake: interval and its status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfi_out_if import bfi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [INTERVAL_BITS-1:0] interval;
  logic [CODE_BITS-1:0]     rollover_code;
  logic                     index_seen;
  logic                     stream_end;

  modport source (output valid, output interval, output rollover_code, output index_seen,
                  output stream_end, input ready);
  modport sink (input valid, input interval, input rollover_code, input index_seen,
                input stream_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfi_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bfi_cfg_if: configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfi_cfg_if import bfi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfi_cfg.sv =====
// ----------------------------------------------------------------------------
// bfi_cfg: configuration registers
// Decodes writes on the configuration channel into the five registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfi_cfg import bfi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bfi_cfg_if.sink    cfg,
  output cfg_t       regs
);

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.sample_period_ps <= RST_SAMPLE_PERIOD;
      regs_q.track_len_cells  <= RST_TRACK_LEN;
      regs_q.track_time_ps    <= RST_TRACK_TIME;
      regs_q.stop_revolution  <= RST_END_REV;
      regs_q.end_position     <= RST_END_POS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SAMPLE_PERIOD: regs_q.sample_period_ps <= cfg.data[PERIOD_BITS-1:0];
        REG_TRACK_LEN:     regs_q.track_len_cells  <= cfg.data[POS_BITS-1:0];
        REG_TRACK_TIME:    regs_q.track_time_ps    <= cfg.data[TIME_BITS-1:0];
        REG_END_REV:       regs_q.stop_revolution  <= cfg.data[REV_BITS-1:0];
        REG_END_POS:       regs_q.end_position     <= cfg.data[POS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfi_div.sv =====
// ----------------------------------------------------------------------------
// bfi_div: bit-serial restoring divider
// Shifts the dividend through one bit per cycle and produces one quotient bit
// per cycle; the dividend is 24, 40 or 64 bits long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfi_div import bfi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIVIDEND_BITS-1:0] dq;
  logic [PERIOD_BITS-1:0]   rem;
  logic [PERIOD_BITS-1:0]   dvs;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic                     busy;
  logic                     done;

  logic [DIVIDEND_BITS-1:0] aligned;
  logic [DIV_CNT_BITS-1:0]  start_cnt;
  logic [PERIOD_BITS:0]     trial;
  logic [PERIOD_BITS+1:0]   diff;
  logic                     fits;

  // The dividend is placed at the top of the shift register so that its
  // most significant bit leaves first.
  always_comb begin
    case (req.len_sel)
      DIV_LEN_POS: begin
        aligned   = {req.dividend[POS_BITS-1:0], (DIVIDEND_BITS - POS_BITS)'(0)};
        start_cnt = DIV_CNT_BITS'(POS_BITS);
      end
      DIV_LEN_TIME: begin
        aligned   = {req.dividend[TIME_BITS-1:0], (DIVIDEND_BITS - TIME_BITS)'(0)};
        start_cnt = DIV_CNT_BITS'(TIME_BITS);
      end
      default: begin
        aligned   = req.dividend;
        start_cnt = DIV_CNT_BITS'(DIVIDEND_BITS);
      end
    endcase
  end

  assign trial = {rem, dq[DIVIDEND_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = !diff[PERIOD_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_BITS'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= start_cnt;
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= aligned;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
      dq  <= {dq[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dq[INTERVAL_BITS-1:0];
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/core/bitcell_to_flux_interval_unit.sv =====
// ----------------------------------------------------------------------------
// bitcell_to_flux_interval_unit: bit cell stream to flux interval converter
// Tracks time and position over a rotating track and turns flux transitions
// into intervals counted in sample periods.
// ----------------------------------------------------------------------------
// Usage:
//   cells  : one item per bit cell (duration of the cell left, data and index
//            bit of the cell reached). Taken when valid and ready are high.
//   pulses : zero or one result item per cell, held in an output register
//            until the receiver takes it.
//   cfg    : register writes, always ready; write only while the unit idles.
// Flow: the unit works on one cell at a time. A cell without a result
//   passes ST_STEP and ST_EVAL back to ST_IDLE; a result with a zero sample
//   period goes on to ST_EMIT with no division. A result whose last pulse lies
//   after the current time needs one 64-bit division, a full track without a
//   pulse otherwise one 40-bit division, any other pulse two 40-bit divisions,
//   all in the bit-serial divider, one quotient bit per cycle. A cell whose
//   position needs a full modulo by the track length adds a 24-bit division.
// Stall: while a result waits in the output register the next cell is still
//   accepted; the unit only stops before loading a second result.
// Reset: synchronous; clears position, time, counters, flags and the output
//   valid, and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitcell_to_flux_interval_unit import bfi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  bfi_in_if.sink    cells,
  bfi_out_if.source pulses,
  bfi_cfg_if.sink   cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_DIV_A = 3'd5;
  localparam logic [2:0] ST_DIV_B = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  cfg_t     regs;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]               state;
  logic [PERIOD_BITS-1:0]   cell_r;
  logic                     data_r;
  logic                     idx_r;
  logic [POS_BITS-1:0]      pos;
  logic [REV_BITS-1:0]      rev;
  logic [TIME_BITS-1:0]     now;
  logic [TIME_BITS-1:0]     last;
  logic                     idx_last;
  logic [POS_BITS-1:0]      since;
  logic                     idx_pend;
  logic                     wrap_pend;
  logic                     end_reached;
  logic [CODE_BITS-1:0]     res_code;
  logic [INTERVAL_BITS-1:0] res_int;
  logic [INTERVAL_BITS-1:0] q_first;
  logic [TIME_BITS-1:0]     gap;
  logic                     le_r;
  logic                     two_step;

  logic                     out_valid;
  logic [INTERVAL_BITS-1:0] out_interval;
  logic [CODE_BITS-1:0]     out_code;
  logic                     out_idx;
  logic                     out_end;

  logic [TIME_BITS-1:0]     time_sum;
  logic [POS_BITS-1:0]      pos_inc;
  logic                     pos_wrap;
  logic [POS_BITS-1:0]      pos_over;
  logic                     pos_small;
  logic [POS_BITS-1:0]      since_inc;
  logic                     last_le_now;
  logic                     no_pulse;
  logic                     pulse;
  logic [TIME_BITS:0]       wrap_diff;
  logic                     out_free;

  // Rising edge of the index level.
  function automatic logic cells_edge_seen(input logic level, input logic level_last);
    return level && !level_last;
  endfunction

  bfi_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bfi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cells.ready = (state == ST_IDLE);

  assign time_sum    = now + TIME_BITS'(cell_r);
  assign pos_inc     = pos + POS_BITS'(1);
  assign pos_wrap    = (pos_inc >= regs.track_len_cells);
  assign pos_over    = pos_inc - regs.track_len_cells;
  assign pos_small   = (pos_over < regs.track_len_cells);
  assign since_inc   = since + POS_BITS'(1);
  assign last_le_now = (last <= now);
  assign no_pulse    = (since_inc == regs.track_len_cells);
  assign pulse       = !no_pulse && data_r;
  assign out_free    = !out_valid || pulses.ready;

  // Wrapped interval: track time less the gap, sign-extended to 64 bits.
  assign wrap_diff = {1'b0, regs.track_time_ps} - {1'b0, gap};

  always_comb begin
    div_req.start    = 1'b0;
    div_req.len_sel  = DIV_LEN_TIME;
    div_req.dividend = '0;
    div_req.divisor  = regs.sample_period_ps;
    case (state)
      ST_STEP: begin
        div_req.start    = pos_wrap && (regs.track_len_cells != '0) && !pos_small;
        div_req.len_sel  = DIV_LEN_POS;
        div_req.dividend = DIVIDEND_BITS'(pos_inc);
        div_req.divisor  = PERIOD_BITS'(regs.track_len_cells);
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        if (le_r) begin
          div_req.len_sel  = DIV_LEN_TIME;
          div_req.dividend = DIVIDEND_BITS'(two_step ? now : gap);
        end else begin
          div_req.len_sel  = DIV_LEN_FULL;
          div_req.dividend = {{(DIVIDEND_BITS - TIME_BITS - 1){wrap_diff[TIME_BITS]}},
                              wrap_diff};
        end
      end
      ST_DIV_A: begin
        div_req.start    = div_rsp.done && two_step;
        div_req.len_sel  = DIV_LEN_TIME;
        div_req.dividend = DIVIDEND_BITS'(last);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      rev         <= '0;
      now         <= '0;
      last        <= '0;
      idx_last    <= 1'b0;
      since       <= '0;
      idx_pend    <= 1'b0;
      wrap_pend   <= 1'b0;
      end_reached <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cells.valid) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          state <= ST_EVAL;
          if (pos_wrap) begin
            now       <= '0;
            rev       <= rev + REV_BITS'(1);
            wrap_pend <= 1'b1;
            if (regs.track_len_cells == '0) begin
              pos <= '0;
            end else if (pos_small) begin
              pos <= pos_over;
            end else begin
              state <= ST_MOD;
            end
          end else begin
            now <= time_sum;
            pos <= pos_inc;
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            pos   <= div_rsp.remainder[POS_BITS-1:0];
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if ((rev >= regs.stop_revolution) && (pos >= regs.end_position)) begin
            end_reached <= 1'b1;
          end
          since <= since_inc;
          if (!no_pulse) begin
            if (cells_edge_seen(idx_r, idx_last)) begin
              idx_pend <= 1'b1;
            end
            idx_last <= idx_r;
          end
          if (no_pulse || pulse) begin
            state <= (regs.sample_period_ps == '0) ? ST_EMIT : ST_LOAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          state <= ST_DIV_A;
        end
        ST_DIV_A: begin
          if (div_rsp.done) begin
            state <= two_step ? ST_DIV_B : ST_EMIT;
          end
        end
        ST_DIV_B: begin
          if (div_rsp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            last      <= now;
            since     <= '0;
            idx_pend  <= 1'b0;
            wrap_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item payload and result datapath.
  always_ff @(posedge clk) begin
    if (cells.valid && cells.ready) begin
      cell_r <= cells.left_cell_ps;
      data_r <= cells.data_bit;
      idx_r  <= cells.index_bit;
    end
    if (state == ST_EVAL) begin
      res_code <= no_pulse ? CODE_NO_PULSE : (wrap_pend ? CODE_WRAPPED : CODE_NONE);
      res_int  <= INTERVAL_SATURATED;
      gap      <= last_le_now ? (now - last) : (last - now);
      le_r     <= last_le_now;
      two_step <= pulse && last_le_now;
    end
    if (state == ST_DIV_A && div_rsp.done) begin
      q_first <= div_rsp.quotient;
      res_int <= div_rsp.quotient;
    end
    if (state == ST_DIV_B && div_rsp.done) begin
      res_int <= q_first - div_rsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (pulses.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_interval <= res_int;
      out_code     <= res_code;
      out_idx      <= idx_pend;
      out_end      <= end_reached;
    end
  end

  assign pulses.valid         = out_valid;
  assign pulses.interval      = out_interval;
  assign pulses.rollover_code = out_code;
  assign pulses.index_seen    = out_idx;
  assign pulses.stream_end    = out_end;

endmodule

`default_nettype wire

// ===== rtl/core/bfi_checker.sv =====
// ----------------------------------------------------------------------------
// bfi_checker: port-level checks of the flux interval unit
// Watches the cell and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfi_checker import bfi_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [INTERVAL_BITS-1:0] out_interval,
  input wire logic [CODE_BITS-1:0]     out_code,
  input wire logic                     out_idx,
  input wire logic                     out_end
);

  // One cell at a time: after an item is taken the unit is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("cell channel ready right after an accepted item");

  // A new result is only produced while the cell channel was held off.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the unit was idle");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_interval) && $stable(out_code)
      && $stable(out_idx) && $stable(out_end))
    else $error("stalled result changed or was dropped");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitcell_to_flux_interval_unit bfi_checker u_bfi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (cells.valid),
  .in_ready     (cells.ready),
  .out_valid    (pulses.valid),
  .out_ready    (pulses.ready),
  .out_interval (pulses.interval),
  .out_code     (pulses.rollover_code),
  .out_idx      (pulses.index_seen),
  .out_end      (pulses.stream_end)
);

`default_nettype wire
